[sv/hsfc_pkg.sv]
package hsfc_pkg;

    // Result frame width and default header ("@STCRTC#", first byte in bits 7..0)
    localparam int OUT_FIELDS = 11;
    localparam logic [63:0] HEADER_RESET = 64'd2540967327060742976;

    typedef logic [7:0] byte_t;
    typedef logic [OUT_FIELDS-1:0][7:0] frame_t;

endpackage

[sv/hsfc_match.sv]
module hsfc_match
    import hsfc_pkg::*;
#(
    parameter int HEADER_LEN = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 frame_done,
    input  byte_t                rx_data,
    input  logic [63:0]          pattern,
    output logic                 header_done,
    output logic [(HEADER_LEN > 1 ? $clog2(HEADER_LEN) : 1)-1:0] match_idx
);

    localparam int MW = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;

    logic [MW-1:0] idx_reg;
    logic [MW-1:0] idx_next;
    logic [MW-1:0] idx_eff;
    logic [MW:0]   idx_inc;
    byte_t         exp_byte;
    logic          hit;

    // Completed frame drops the index before this byte is compared
    assign idx_eff  = frame_done ? '0 : idx_reg;
    assign exp_byte = pattern[idx_eff*8 +: 8];
    assign hit      = (rx_data == exp_byte);
    assign idx_inc  = {1'b0, idx_eff} + {{MW{1'b0}}, 1'b1};

    // Advance on a match, restart naively on a miss
    always_comb
    begin
        header_done = 1'b0;
        idx_next    = idx_reg;
        if (advance)
        begin
            if (hit)
            begin
                if (idx_inc == (MW+1)'(HEADER_LEN))
                begin
                    header_done = 1'b1;
                    idx_next    = '0;
                end
                else
                begin
                    idx_next = idx_inc[MW-1:0];
                end
            end
            else if (rx_data == pattern[7:0])
            begin
                idx_next = MW'(1);
            end
            else
            begin
                idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign match_idx = idx_reg;

endmodule

[sv/hsfc_capture.sv]
module hsfc_capture
    import hsfc_pkg::*;
#(
    parameter int PAYLOAD_LEN = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 header_done,
    input  byte_t                rx_data,
    output logic                 frame_done,
    output frame_t               frame,
    output logic [$clog2(PAYLOAD_LEN+1)-1:0] count
);

    localparam int CW = $clog2(PAYLOAD_LEN + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    byte_t         store_reg [PAYLOAD_LEN];

    // Last payload byte arrives while the count sits at PAYLOAD_LEN
    assign frame_done = (count_reg == CW'(PAYLOAD_LEN));

    // Step the count; a header match restarts the capture
    always_comb
    begin
        count_next = count_reg;
        if (advance)
        begin
            if (header_done)
            begin
                count_next = CW'(1);
            end
            else if (frame_done)
            begin
                count_next = '0;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Store each payload byte in its slot
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < PAYLOAD_LEN; j++)
        begin
            if (advance && count_reg == CW'(j + 1))
            begin
                store_reg[j] <= rx_data;
            end
        end
    end

    // Assemble the frame: stored bytes, the current byte last, zeros past the payload
    for (genvar g = 0; g < OUT_FIELDS; g++)
    begin : g_frame
        if (g == PAYLOAD_LEN - 1)
        begin : g_last
            assign frame[g] = rx_data;
        end
        else if (g < PAYLOAD_LEN)
        begin : g_stored
            assign frame[g] = store_reg[g];
        end
        else
        begin : g_zero
            assign frame[g] = '0;
        end
    end

    assign count = count_reg;

endmodule

[sv/header_sync_frame_capture_core.sv]
// Timing: an accepted byte is registered in the input register and processed from
// there; a completed frame is loaded into the output register as its last byte advances.
// Throughput: one byte per cycle; the input register stalls only when a frame
// completes while the output register still holds an untaken frame.
// Reset: match index, capture count and valid flags clear; header_reg returns
// to "@STCRTC#". The payload store is not reset.
module header_sync_frame_capture_core
    import hsfc_pkg::*;
#(
    parameter int HEADER_LEN  = 8,
    parameter int PAYLOAD_LEN = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  century_byte,
    output logic [7:0]  year_byte,
    output logic [7:0]  month_byte,
    output logic [7:0]  day_byte,
    output logic [7:0]  spare_byte,
    output logic [7:0]  hour_byte,
    output logic [7:0]  minute_byte,
    output logic [7:0]  second_byte,
    output logic [7:0]  tick_byte,
    output logic [7:0]  milli_high,
    output logic [7:0]  milli_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] header_pattern
);

    localparam int MW = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;
    localparam int CW = $clog2(PAYLOAD_LEN + 1);

    logic          in_vld_reg;
    logic          in_vld_next;
    byte_t         byte_reg;
    logic [63:0]   header_reg;
    logic          out_vld_reg;
    logic          out_vld_next;
    frame_t        frame_reg;
    frame_t        frame;
    logic          advance;
    logic          out_free;
    logic          frame_done;
    logic          header_done;
    logic [MW-1:0] match_idx;
    logic [CW-1:0] count;

    // Handshake control
    assign out_free = !out_vld_reg || out_ready;
    assign advance  = in_vld_reg && (!frame_done || out_free);
    assign in_ready = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = (advance && frame_done) ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    // Hold control flags and the header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            header_reg  <= HEADER_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                header_reg <= header_pattern;
            end
        end
    end

    // Load the input byte and the finished frame
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && frame_done)
        begin
            frame_reg <= frame;
        end
    end

    hsfc_match #(
        .HEADER_LEN (HEADER_LEN)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .frame_done  (frame_done),
        .rx_data     (byte_reg),
        .pattern     (header_reg),
        .header_done (header_done),
        .match_idx   (match_idx)
    );

    hsfc_capture #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .header_done (header_done),
        .rx_data     (byte_reg),
        .frame_done  (frame_done),
        .frame       (frame),
        .count       (count)
    );

    // Drive result fields
    assign out_valid    = out_vld_reg;
    assign century_byte = frame_reg[0];
    assign year_byte    = frame_reg[1];
    assign month_byte   = frame_reg[2];
    assign day_byte     = frame_reg[3];
    assign spare_byte   = frame_reg[4];
    assign hour_byte    = frame_reg[5];
    assign minute_byte  = frame_reg[6];
    assign second_byte  = frame_reg[7];
    assign tick_byte    = frame_reg[8];
    assign milli_high   = frame_reg[9];
    assign milli_low    = frame_reg[10];

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(PAYLOAD_LEN))
        else $error("capture count out of range");

    a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, match_idx} < (MW+1)'(HEADER_LEN))
        else $error("match index out of range");

    a_frame_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_done |=> out_valid)
        else $error("completed frame not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready && frame_done |-> !advance)
        else $error("pending frame overwritten");

endmodule
